FILE: rtl/image_double_bilinear_macros.svh
// Assertion macros shared by the image doubler RTL.
`ifndef IMAGE_DOUBLE_BILINEAR_MACROS_SVH
`define IMAGE_DOUBLE_BILINEAR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define IBD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define IBD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/ibd_pkg.sv
// Package with types, constants and glyph lookup for the image doubler.
`timescale 1ns / 1ps
package ibd_pkg;

   // Configuration register indexes
   localparam logic [1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_GREY_LEVELS  = 2'd2;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 9;

   // Grey-level modes
   localparam logic [3:0] MODE_TWO   = 4'd2;
   localparam logic [3:0] MODE_THREE = 4'd3;
   localparam logic [3:0] MODE_FOUR  = 4'd4;

   // ASCII glyphs
   localparam logic [6:0] GLYPH_HASH  = 7'h23;
   localparam logic [6:0] GLYPH_COLON = 7'h3A;
   localparam logic [6:0] GLYPH_DOT   = 7'h2E;
   localparam logic [6:0] GLYPH_SPACE = 7'h20;
   localparam logic [6:0] GLYPH_NONE  = 7'h4E;

   // Result kinds, in emit order
   localparam logic [1:0] KIND_CENTRE     = 2'd0;
   localparam logic [1:0] KIND_VERTICAL   = 2'd1;
   localparam logic [1:0] KIND_HORIZONTAL = 2'd2;
   localparam logic [1:0] KIND_COPY       = 2'd3;
   localparam int unsigned NUM_KINDS = 4;

   // Work queue between front and back
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_LVL_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [8:0] image_width;
      logic [8:0] image_height;
      logic [3:0] grey_levels;
   } cfg_type;

   typedef struct packed {
      logic [7:0] src_pixel;
   } req_payload_type;

   typedef struct packed {
      logic [8:0] out_x;
      logic [8:0] out_y;
      logic [7:0] out_value;
      logic [6:0] glyph;
      logic       last_of_item;
      logic       image_end;
   } rsp_payload_type;

   typedef struct packed {
      logic [NUM_KINDS-1:0]                   present;
      rsp_payload_type [NUM_KINDS-1:0]        res;
   } work_type;

   typedef struct packed {
      logic                   not_empty;
      logic [QUEUE_LVL_W-1:0] level;
   } queue_status_type;

   // Glyph for a value; in_range is set when the value is below four.
   function automatic logic [6:0] glyph_of(input logic in_range, input logic [1:0] v,
                                           input logic [3:0] mode);
      logic [6:0] g;
      g = GLYPH_NONE;
      if (in_range) begin
         unique case (mode)
            MODE_TWO: begin
               if (v == 2'd0) g = GLYPH_HASH;
               else if (v == 2'd1) g = GLYPH_SPACE;
            end
            MODE_THREE: begin
               if (v == 2'd0) g = GLYPH_HASH;
               else if (v == 2'd1) g = GLYPH_DOT;
               else if (v == 2'd2) g = GLYPH_SPACE;
            end
            MODE_FOUR: begin
               unique case (v)
                  2'd0: g = GLYPH_HASH;
                  2'd1: g = GLYPH_COLON;
                  2'd2: g = GLYPH_DOT;
                  default: g = GLYPH_SPACE;
               endcase
            end
            default: g = GLYPH_NONE;
         endcase
      end
      return g;
   endfunction

endpackage

FILE: rtl/ibd_stream_if.sv
// Valid/ready stream interface carrying one payload per transaction.
`timescale 1ns / 1ps
interface ibd_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/image_double_bilinear.sv
// Top level of the streaming 2x bilinear image doubler.
//
//   channel   dir  handshake                     payload
//   req_chan  in   valid/ready                   src_pixel
//   rsp_chan  out  valid/ready                   out_x, out_y, out_value, glyph,
//                                                last_of_item, image_end
//   csr       in   csr_write, no wait, no read   csr_index, csr_wdata
//
// Each pixel yields one to four transactions on rsp_chan, one per cycle while rsp_chan is
// ready; an image interior pixel yields four, edge pixels one or two. The front end
// takes one pixel per cycle while the work queue has room; the output register drives
// the rate, and the first result of a pixel passes stage one, the work queue and the
// back-end work register before the output register presents it on rsp_chan.
// Reset is synchronous and clears counters, queue and handshake state; the row store
// has no clearing pass, each entry is written by the first row before its value is used.
// A stalled rsp_chan fills the four-entry queue; req_chan.ready drops once the queued
// items plus the pixel held in front stage one reach four.
`timescale 1ns / 1ps
module image_double_bilinear #(
   parameter int unsigned MAX_WIDTH  = 256,
   parameter int unsigned MAX_HEIGHT = 256,
   parameter int unsigned PIXEL_BITS = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   ibd_stream_if.sink                         req_chan,
   ibd_stream_if.source                       rsp_chan,
   input  logic                               csr_write,
   input  logic [ibd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ibd_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   // Configuration registers
   logic [8:0] width_ff, width_in;
   logic [8:0] height_ff, height_in;
   logic [3:0] grey_ff, grey_in;
   ibd_pkg::cfg_type cfg;

   // Front to queue, queue to back
   logic                      q_push;
   logic                      q_pop;
   ibd_pkg::work_type         q_entry;
   ibd_pkg::work_type         q_head;
   ibd_pkg::queue_status_type q_status;

   // Decode register writes; an index past the list is dropped
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      grey_in   = grey_ff;
      if (csr_write) begin
         unique case (csr_index)
            ibd_pkg::CSR_IMAGE_WIDTH:  width_in  = csr_wdata;
            ibd_pkg::CSR_IMAGE_HEIGHT: height_in = csr_wdata;
            ibd_pkg::CSR_GREY_LEVELS:  grey_in   = csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 9'd1;
         height_ff <= 9'd1;
         grey_ff   <= ibd_pkg::MODE_FOUR;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         grey_ff   <= grey_in;
      end
   end

   assign cfg.image_width  = width_ff;
   assign cfg.image_height = height_ff;
   assign cfg.grey_levels  = grey_ff;

   // Front: position tracking, row store, averages, result words
   ibd_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req      (req_chan),
      .q_status (q_status),
      .q_push   (q_push),
      .q_entry  (q_entry)
   );

   // Queue decouples pixel intake from result output
   ibd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .head       (q_head),
      .status     (q_status)
   );

   // Back: one result transaction per cycle while rsp_chan is ready, in centre, vertical, horizontal, copy order
   ibd_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (q_head),
      .q_status (q_status),
      .q_pop    (q_pop),
      .rsp      (rsp_chan)
   );

endmodule

FILE: rtl/ibd_front.sv
// Front end: accepts pixels, tracks position, reads the row store, builds results.
`timescale 1ns / 1ps
module ibd_front #(
   parameter int unsigned MAX_WIDTH  = 256,
   parameter int unsigned MAX_HEIGHT = 256,
   parameter int unsigned PIXEL_BITS = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  ibd_pkg::cfg_type           cfg,
   ibd_stream_if.sink                 req,
   input  ibd_pkg::queue_status_type  q_status,
   output logic                       q_push,
   output ibd_pkg::work_type          q_entry
);
   localparam int unsigned CW = $clog2(MAX_WIDTH);
   localparam int unsigned RW = $clog2(MAX_HEIGHT);
   localparam int unsigned PW = PIXEL_BITS;
   localparam int unsigned WCMP = (CW + 1 > 9) ? CW + 1 : 9;
   localparam int unsigned HCMP = (RW + 1 > 9) ? RW + 1 : 9;
   localparam int unsigned LVW  = ibd_pkg::QUEUE_LVL_W + 1;

   logic [PW-1:0] row_mem [MAX_WIDTH];

   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic          s1_valid_ff, s1_valid_in;
   logic [PW-1:0] s1_cur_ff;
   logic [CW-1:0] s1_col_ff;
   logic [RW-1:0] s1_row_ff;
   logic          s1_row_end_ff;
   logic          s1_img_end_ff;
   logic [PW-1:0] above_ff;
   logic [PW-1:0] left_ff, left_in;
   logic [PW-1:0] upleft_ff, upleft_in;

   logic          accept;
   logic [PW-1:0] cur;
   logic [CW:0]   col_next;
   logic [RW:0]   row_next;
   logic          row_end;
   logic          img_end;
   logic          has_left, has_up;
   logic [PW+1:0] sum4;
   logic [PW:0]   sum_v, sum_h;
   logic [PW-1:0] val_c, val_v, val_h;
   logic [8:0]    x_even, x_odd, y_even, y_odd;

   function automatic ibd_pkg::rsp_payload_type build(input logic [8:0] x,
                                                      input logic [8:0] y,
                                                      input logic [PW-1:0] v,
                                                      input logic last,
                                                      input logic fin,
                                                      input logic [3:0] mode);
      ibd_pkg::rsp_payload_type r;
      logic [PW+1:0] ext;
      ext = (PW+2)'(v);
      r.out_x        = x;
      r.out_y        = y;
      r.out_value    = 8'(v);
      r.glyph        = ibd_pkg::glyph_of(ext[PW+1:2] == '0, ext[1:0], mode);
      r.last_of_item = last;
      r.image_end    = fin;
      return r;
   endfunction

   // Room for the item in stage one as well as everything already queued
   assign req.ready = ((LVW)'(q_status.level) + (LVW)'(s1_valid_ff))
                      < (LVW)'(ibd_pkg::QUEUE_DEPTH);
   assign accept = req.valid && req.ready;
   assign cur    = PW'(req.payload.src_pixel);

   // Row and image end
   assign col_next = (CW+1)'(col_ff) + (CW+1)'(1);
   assign row_next = (RW+1)'(row_ff) + (RW+1)'(1);
   assign row_end  = (WCMP'(col_next) >= WCMP'(cfg.image_width))
                     || (col_next == (CW+1)'(MAX_WIDTH));
   assign img_end  = row_end && ((HCMP'(row_next) >= HCMP'(cfg.image_height))
                     || (row_next == (RW+1)'(MAX_HEIGHT)));

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (row_end) begin
            col_in = '0;
            row_in = img_end ? '0 : RW'(row_next);
         end else begin
            col_in = CW'(col_next);
         end
      end
   end

   assign s1_valid_in = accept;

   // Row store: read-first, so a pixel sees the value above it
   always_ff @(posedge clock) begin
      if (accept) begin
         row_mem[col_ff] <= cur;
         above_ff        <= row_mem[col_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cur_ff     <= cur;
         s1_col_ff     <= col_ff;
         s1_row_ff     <= row_ff;
         s1_row_end_ff <= row_end;
         s1_img_end_ff <= img_end;
      end
   end

   // Stage one: averages and result words
   assign has_left = s1_col_ff != '0;
   assign has_up   = s1_row_ff != '0;
   assign sum4  = (PW+2)'(upleft_ff) + (PW+2)'(above_ff) + (PW+2)'(left_ff)
                  + (PW+2)'(s1_cur_ff) + (PW+2)'(1);
   assign sum_v = (PW+1)'(above_ff) + (PW+1)'(s1_cur_ff);
   assign sum_h = (PW+1)'(left_ff) + (PW+1)'(s1_cur_ff);
   assign val_c = sum4[PW+1:2];
   assign val_v = sum_v[PW:1];
   assign val_h = sum_h[PW:1];
   assign x_even = 9'({s1_col_ff, 1'b0});
   assign y_even = 9'({s1_row_ff, 1'b0});
   assign x_odd  = x_even - 9'd1;
   assign y_odd  = y_even - 9'd1;

   always_comb begin
      q_entry.present = '0;
      q_entry.present[ibd_pkg::KIND_CENTRE]     = has_left && has_up;
      q_entry.present[ibd_pkg::KIND_VERTICAL]   = has_up;
      q_entry.present[ibd_pkg::KIND_HORIZONTAL] = has_left;
      q_entry.present[ibd_pkg::KIND_COPY]       = 1'b1;
      q_entry.res[ibd_pkg::KIND_CENTRE] =
         build(x_odd, y_odd, val_c, 1'b0, 1'b0, cfg.grey_levels);
      q_entry.res[ibd_pkg::KIND_VERTICAL] =
         build(x_even, y_odd, val_v, 1'b0, 1'b0, cfg.grey_levels);
      q_entry.res[ibd_pkg::KIND_HORIZONTAL] =
         build(x_odd, y_even, val_h, 1'b0, 1'b0, cfg.grey_levels);
      q_entry.res[ibd_pkg::KIND_COPY] =
         build(x_even, y_even, s1_cur_ff, 1'b1, s1_img_end_ff, cfg.grey_levels);
   end

   assign q_push = s1_valid_ff;

   // Neighbor registers advance as each item leaves stage one
   always_comb begin
      left_in   = left_ff;
      upleft_in = upleft_ff;
      if (s1_valid_ff) begin
         if (s1_row_end_ff) begin
            left_in   = '0;
            upleft_in = '0;
         end else begin
            left_in   = s1_cur_ff;
            upleft_in = above_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
         left_ff     <= '0;
         upleft_ff   <= '0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
         left_ff     <= left_in;
         upleft_ff   <= upleft_in;
      end
   end

endmodule

FILE: rtl/ibd_queue.sv
// Small work queue between the front and back ends.
`timescale 1ns / 1ps
`include "image_double_bilinear_macros.svh"
module ibd_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  ibd_pkg::work_type          push_entry,
   input  logic                       pop,
   output ibd_pkg::work_type          head,
   output ibd_pkg::queue_status_type  status
);
   localparam int unsigned PW = ibd_pkg::QUEUE_PTR_W;
   localparam int unsigned LW = ibd_pkg::QUEUE_LVL_W;

   ibd_pkg::work_type slots [ibd_pkg::QUEUE_DEPTH];

   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [LW-1:0] level_ff, level_in;

   always_ff @(posedge clock) begin
      if (push) slots[wr_ptr_ff] <= push_entry;
   end

   assign head = slots[rd_ptr_ff];
   assign status.not_empty = level_ff != '0;
   assign status.level     = level_ff;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      level_in  = level_ff;
      if (push && !pop) level_in = level_ff + LW'(1);
      else if (pop && !push) level_in = level_ff - LW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   `IBD_ASSERT_NOW(a_q_no_overflow, clock, reset, push, (level_ff != LW'(ibd_pkg::QUEUE_DEPTH)) || pop, "work queue overflow")
   `IBD_ASSERT_NOW(a_q_no_underflow, clock, reset, pop, level_ff != '0, "work queue underflow")

endmodule

FILE: rtl/ibd_back.sv
// Back end: walks the pending results of one item onto the output register.
`timescale 1ns / 1ps
`include "image_double_bilinear_macros.svh"
module ibd_back (
   input  logic                       clock,
   input  logic                       reset,
   input  ibd_pkg::work_type          head,
   input  ibd_pkg::queue_status_type  q_status,
   output logic                       q_pop,
   ibd_stream_if.source               rsp
);
   localparam int unsigned NK = ibd_pkg::NUM_KINDS;

   logic                     cur_valid_ff, cur_valid_in;
   logic [NK-1:0]            pend_ff, pend_in;
   ibd_pkg::work_type        work_ff, work_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   ibd_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;

   logic       out_free;
   logic       emit;
   logic       last_emit;
   logic [1:0] sel;

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign emit     = cur_valid_ff && out_free;

   // Lowest pending kind goes first
   always_comb begin
      if (pend_ff[ibd_pkg::KIND_CENTRE])          sel = ibd_pkg::KIND_CENTRE;
      else if (pend_ff[ibd_pkg::KIND_VERTICAL])   sel = ibd_pkg::KIND_VERTICAL;
      else if (pend_ff[ibd_pkg::KIND_HORIZONTAL]) sel = ibd_pkg::KIND_HORIZONTAL;
      else                                        sel = ibd_pkg::KIND_COPY;
   end

   assign last_emit = emit && (sel == ibd_pkg::KIND_COPY);
   assign q_pop     = q_status.not_empty && (!cur_valid_ff || last_emit);

   always_comb begin
      cur_valid_in = cur_valid_ff;
      pend_in      = pend_ff;
      work_in      = work_ff;
      if (q_pop) begin
         cur_valid_in = 1'b1;
         pend_in      = head.present;
         work_in      = head;
      end else if (emit) begin
         pend_in = pend_ff & ~(NK'(1) << sel);
         if (last_emit) cur_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = work_ff.res[sel];
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_data_ff;

   always_ff @(posedge clock) begin
      work_ff     <= work_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         pend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `IBD_ASSERT_NOW(a_back_copy_pending, clock, reset, cur_valid_ff, pend_ff[ibd_pkg::KIND_COPY], "active item lost its copy result")
   `IBD_ASSERT_NOW(a_back_pop_has_copy, clock, reset, q_pop, head.present[ibd_pkg::KIND_COPY], "queued item without copy result")

endmodule
